/* rtl/pta_pkg.sv */
`timescale 1ns / 1ps
// Package for the pressure-to-altitude converter: payload types, register
// indexes, fixed-point constants, a log2 normalize helper and elaboration-time
// square-root helpers. No dependencies.
package pta_pkg;

  typedef logic [16:0]        pressure_t;
  typedef logic signed [15:0] alt_m_t;
  typedef logic signed [17:0] alt_ft_t;

  typedef enum logic [1:0] {
    CFG_QNH    = 2'd0,
    CFG_OFFSET = 2'd1
  } cfg_index_t;

  localparam logic [10:0] QNH_RESET    = 11'd1013;
  localparam logic [5:0]  OFFSET_RESET = 6'd2;
  localparam logic [23:0] EXP_COEF     = 24'd12770478;
  localparam logic [17:0] FT_COEF      = 18'd215013;
  localparam logic [16:0] ALT_SCALE    = 17'd44330;
  localparam logic [21:0] M_NEG_MAX    = 22'd4000;
  localparam logic [21:0] M_POS_MAX    = 22'd30000;
  localparam logic [23:0] FT_NEG_MAX   = 24'd13000;
  localparam logic [23:0] FT_POS_MAX   = 24'd100000;

  function automatic logic [4:0] msb_pos(input logic [17:0] x);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 1; k < 18; k++) begin
      if (x[k]) n = 5'(k);
    end
    return n;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-i) in Q2.30
  function automatic logic [31:0] root_q30(input int i);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 1; k <= 32; k++) begin
      if (k <= i) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

/* rtl/pta_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the pressure-to-altitude converter: one pressure word.
// Depends on pta_pkg.
interface pta_in_if;
  logic                valid;
  logic                ready;
  pta_pkg::pressure_t  pressure_pa;

  modport source (output valid, output pressure_pa, input ready);
  modport sink   (input valid, input pressure_pa, output ready);
endinterface

/* rtl/pta_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the pressure-to-altitude converter: altitude in m and ft.
// Depends on pta_pkg.
interface pta_out_if;
  logic              valid;
  logic              ready;
  pta_pkg::alt_m_t   alt_meters;
  pta_pkg::alt_ft_t  alt_feet;

  modport source (output valid, output alt_meters, output alt_feet, input ready);
  modport sink   (input valid, input alt_meters, input alt_feet, output ready);
endinterface

/* rtl/pta_log2.sv */
`timescale 1ns / 1ps
// Pipelined fixed-point log2: normalize stage, then one squaring stage per
// fraction bit; all stages advance only while en is high. Depends on pta_pkg.
module pta_log2 #(
  parameter int FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [17:0]            x,
  output logic [FRAC_BITS+4:0]   l
);

  logic [30:0]          m_r    [0:FRAC_BITS];
  logic [4:0]           n_r    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_r [0:FRAC_BITS];
  logic [4:0]           n0;
  logic [30:0]          xe;

  assign n0 = pta_pkg::msb_pos(x);
  assign xe = {13'd0, x};

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= xe << (5'd30 - n0);
      n_r[0]    <= n0;
      frac_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] s;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign s  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]    <= s[31] ? s[31:1] : s[30:0];
        n_r[k]    <= n_r[k-1];
        frac_r[k] <= {frac_r[k-1][FRAC_BITS-2:0], s[31]};
      end
    end
  end

  assign l = {n_r[FRAC_BITS], frac_r[FRAC_BITS]};

endmodule

/* rtl/pressure_to_altitude.sv */
`timescale 1ns / 1ps
// Pressure altitude converter (ISA barometric formula). Accepts one word per
// cycle while the output is not held; each result passes through the log2
// squaring chains and the exp2 multiply chain, one multiplier per stage of each chain.
// Whole pipeline holds while the output word waits. Depends on pta_pkg.
module pressure_to_altitude #(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  pta_in_if.sink       in_word,
  pta_out_if.source    out_word,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data
);

  localparam int TOT = 2 * FRAC_BITS + 9;
  localparam int FB  = FRAC_BITS;

  logic [10:0] qnh_r;
  logic [5:0]  off_r;
  logic        en;
  logic [TOT-1:0] vld_r;
  logic [TOT-1:0] zero_r;

  assign en           = !vld_r[TOT-1] || out_word.ready;
  assign in_word.ready = en;
  assign out_word.valid = vld_r[TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qnh_r <= pta_pkg::QNH_RESET;
      off_r <= pta_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pta_pkg::CFG_QNH:    qnh_r <= cfg_data;
        pta_pkg::CFG_OFFSET: off_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic signed [12:0] ref_hpa;
  logic [12:0]        ref_cl;
  logic [17:0]        ref_pa;
  assign ref_hpa = $signed({2'b00, qnh_r}) + 13'(signed'(off_r));
  assign ref_cl  = (ref_hpa < 13'sd1) ? 13'd1 : ref_hpa;
  assign ref_pa  = 18'(ref_cl * 18'd100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_word.valid};
    end
  end

  logic [17:0] p_a_r;
  logic [17:0] ref_a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r   <= {1'b0, in_word.pressure_pa};
      ref_a_r <= ref_pa;
      zero_r  <= {zero_r[TOT-2:0], (in_word.pressure_pa == '0)};
    end
  end

  logic [FB+4:0] lp;
  logic [FB+4:0] lr;
  pta_log2 #(.FRAC_BITS(FB)) u_log_p (.clk(clk), .en(en), .x(p_a_r),   .l(lp));
  pta_log2 #(.FRAC_BITS(FB)) u_log_r (.clk(clk), .en(en), .x(ref_a_r), .l(lr));

  logic signed [FB+5:0] l_r;
  always_ff @(posedge clk) begin
    if (en) l_r <= $signed({1'b0, lp}) - $signed({1'b0, lr});
  end

  logic [FB+4:0]  lm;
  logic [FB+28:0] yprod;
  logic [FB+2:0]  ym_r;
  logic           yneg_r;
  assign lm    = l_r[FB+5] ? (FB+5)'(-l_r) : l_r[FB+4:0];
  assign yprod = (FB+29)'(lm) * (FB+29)'(pta_pkg::EXP_COEF);
  always_ff @(posedge clk) begin
    if (en) begin
      ym_r   <= yprod[FB+28:26];
      yneg_r <= l_r[FB+5];
    end
  end

  logic [FB+3:0]        tsum;
  logic [FB+3:0]        tneg;
  logic signed [3:0]    n_d;
  logic [FB-1:0]        f_d;
  assign tsum = {1'b0, ym_r} + {4'd0, {FB{1'b1}}};
  assign tneg = -{1'b0, ym_r};
  always_comb begin
    if (yneg_r) begin
      n_d = -$signed(4'(tsum[FB+3:FB]));
      f_d = tneg[FB-1:0];
    end else begin
      n_d = $signed({1'b0, ym_r[FB+2:FB]});
      f_d = ym_r[FB-1:0];
    end
  end

  logic [30:0]        pw_r [0:FB];
  logic [FB-1:0]      f_r  [0:FB];
  logic signed [3:0]  n_r  [0:FB];
  always_ff @(posedge clk) begin
    if (en) begin
      pw_r[0] <= 31'd1 << 30;
      f_r[0]  <= f_d;
      n_r[0]  <= n_d;
    end
  end

  for (genvar i = 1; i <= FB; i++) begin : g_exp
    localparam logic [31:0] RC = pta_pkg::root_q30(i);
    logic [62:0] prod;
    assign prod = 63'(pw_r[i-1]) * 63'(RC);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[i] <= f_r[i-1][FB-i] ? prod[60:30] : pw_r[i-1];
        f_r[i]  <= f_r[i-1];
        n_r[i]  <= n_r[i-1];
      end
    end
  end

  logic [34:0] pw_ext;
  logic [34:0] power_r;
  assign pw_ext = {4'd0, pw_r[FB]};
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[2*FB+4]) begin
        power_r <= '0;
      end else if (n_r[FB] >= 4'sd0) begin
        power_r <= pw_ext << n_r[FB];
      end else begin
        power_r <= pw_ext >> 4'(-n_r[FB]);
      end
    end
  end

  logic signed [35:0] adiff;
  logic signed [52:0] alt_r;
  assign adiff = $signed(36'd1 << 30) - $signed({1'b0, power_r});
  always_ff @(posedge clk) begin
    if (en) alt_r <= 53'(adiff) * $signed({36'd0, pta_pkg::ALT_SCALE});
  end

  logic [51:0] mag;
  logic [53:0] ftprod;
  logic [21:0] mm_r;
  logic [23:0] ftm_r;
  logic        neg_r;
  assign mag    = alt_r[52] ? 52'(-alt_r) : alt_r[51:0];
  assign ftprod = 54'(mag[51:16]) * 54'(pta_pkg::FT_COEF);
  always_ff @(posedge clk) begin
    if (en) begin
      mm_r  <= mag[51:30];
      ftm_r <= ftprod[53:30];
      neg_r <= alt_r[52];
    end
  end

  pta_pkg::alt_m_t  m_out_r;
  pta_pkg::alt_ft_t ft_out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r) begin
        m_out_r  <= (mm_r > pta_pkg::M_NEG_MAX) ? -16'sd4000 : -$signed(16'(mm_r));
        ft_out_r <= (ftm_r > pta_pkg::FT_NEG_MAX) ? -18'sd13000 : -$signed(18'(ftm_r));
      end else begin
        m_out_r  <= (mm_r > pta_pkg::M_POS_MAX) ? 16'sd30000 : $signed(16'(mm_r));
        ft_out_r <= (ftm_r > pta_pkg::FT_POS_MAX) ? 18'sd100000 : $signed(18'(ftm_r));
      end
    end
  end

  assign out_word.alt_meters = m_out_r;
  assign out_word.alt_feet   = ft_out_r;

endmodule

/* sim/pressure_to_altitude_test.sv */
`timescale 1ns / 1ps
// Testbench for pressure_to_altitude: drives pressure words, predicts the
// altitude in m and ft from a fixed-point model of its own and checks each
// result. Depends on pta_pkg, pta_in_if, pta_out_if and the RTL top.
module pressure_to_altitude_test;

  localparam int FB = 24;
  localparam int LATENCY = 2 * FB + 9;
  localparam int WORDS_PER_PHASE = 275;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef longint unsigned u64_t;

  typedef struct packed {
    pta_pkg::alt_m_t  m;
    pta_pkg::alt_ft_t ft;
  } altitude_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  pta_in_if  in_word ();
  pta_out_if out_word ();

  pressure_to_altitude #(.FRAC_BITS(FB)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  u64_t                root_q30_tab [0:FB];
  int unsigned         qnh_hpa;
  int                  qnh_offset;
  pta_pkg::pressure_t  pressure_q[$];
  altitude_t           altitude_q[$];
  int                  errors;
  int                  send_idle;
  int                  recv_idle;
  logic                in_took;

  function automatic u64_t int_sqrt(u64_t v);
    u64_t r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint log2_q(u64_t x);
    int n;
    u64_t m, frac;
    n = 0;
    for (int k = 1; k < 40; k++) if (x[k]) n = k;
    m = x << (30 - n);
    frac = 0;
    for (int k = 0; k < FB; k++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= 2 * ONE_Q30) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return longint'(n) * (longint'(1) << FB) + longint'(frac);
  endfunction

  function automatic u64_t exp2_q(longint y);
    longint one, n;
    u64_t f, p;
    one = longint'(1) << FB;
    p = ONE_Q30;
    if (y >= 0) n = y / one;
    else n = -longint'((u64_t'(-y) + u64_t'(one - 1)) >> FB);
    f = u64_t'(y - n * one);
    for (int i = 1; i <= FB; i++)
      if ((f >> (FB - i)) & 1) p = (p * root_q30_tab[i]) >> 30;
    if (n >= 0) begin
      if (n > 30) n = 30;
      p <<= n;
    end else begin
      if (n < -62) return 0;
      p >>= -n;
    end
    return p;
  endfunction

  function automatic altitude_t predict_altitude(pta_pkg::pressure_t p);
    int ref_hpa;
    longint l, alt, m, ft;
    u64_t lm, ym, power, mag;
    bit neg;
    altitude_t a;
    ref_hpa = int'(qnh_hpa) + qnh_offset;
    if (ref_hpa < 1) ref_hpa = 1;
    if (p == 0) begin
      power = 0;
    end else begin
      l = log2_q(u64_t'(p)) - log2_q(u64_t'(ref_hpa) * 100);
      lm = (l < 0) ? u64_t'(-l) : u64_t'(l);
      ym = (lm * 12770478) >> 26;
      power = exp2_q((l < 0) ? -longint'(ym) : longint'(ym));
    end
    alt = 44330 * (longint'(ONE_Q30) - longint'(power));
    neg = alt < 0;
    mag = neg ? u64_t'(-alt) : u64_t'(alt);
    m = longint'(mag >> 30);
    ft = longint'(((mag >> 16) * 215013) >> 30);
    if (neg) begin
      m = -m;
      ft = -ft;
    end
    if (m < -4000) m = -4000;
    if (m > 30000) m = 30000;
    if (ft < -13000) ft = -13000;
    if (ft > 100000) ft = 100000;
    a.m = pta_pkg::alt_m_t'(m);
    a.ft = pta_pkg::alt_ft_t'(ft);
    return a;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_word.valid <= 1'b0;
    end else if (!in_word.valid || in_took) begin
      if (pressure_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_word.valid <= 1'b1;
        in_word.pressure_pa <= pressure_q.pop_front();
      end else begin
        in_word.valid <= 1'b0;
      end
    end
    out_word.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    altitude_t want;
    in_took <= rst_n && in_word.valid && in_word.ready;
    if (rst_n && in_word.valid && in_word.ready)
      altitude_q.push_back(predict_altitude(in_word.pressure_pa));
    if (rst_n && out_word.valid && out_word.ready) begin
      if (altitude_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word m=%0d ft=%0d", $time,
                 out_word.alt_meters, out_word.alt_feet);
      end else begin
        want = altitude_q.pop_front();
        if (out_word.alt_meters !== want.m) begin
          errors++;
          $display("%0t: alt_meters expected %0d actual %0d", $time, want.m,
                   out_word.alt_meters);
        end
        if (out_word.alt_feet !== want.ft) begin
          errors++;
          $display("%0t: alt_feet expected %0d actual %0d", $time, want.ft,
                   out_word.alt_feet);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [10:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pta_pkg::CFG_QNH) qnh_hpa = value;
    else if (idx == pta_pkg::CFG_OFFSET) qnh_offset = int'($signed(value[5:0]));
  endtask

  task automatic drain();
    wait (pressure_q.size() == 0 && !in_word.valid && altitude_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    int qnh_set[6];
    int off_set[6];
    int r;
    qnh_set = '{1013, 900, 1100, 0, 2047, 1013};
    off_set = '{2, -20, 20, -32, 31, 0};
    errors = 0;
    in_took = 1'b0;
    in_word.valid = 1'b0;
    in_word.pressure_pa = '0;
    out_word.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pta_pkg::CFG_QNH;
    cfg_data = '0;
    qnh_hpa = 1013;
    qnh_offset = 2;
    send_idle = 0;
    recv_idle = 0;
    root_q30_tab[0] = 2 * ONE_Q30;
    for (int i = 1; i <= FB; i++) root_q30_tab[i] = int_sqrt(root_q30_tab[i - 1] << 30);
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (qnh_set[ph]) begin
      if (ph > 0) begin
        write_reg(pta_pkg::CFG_QNH, 11'(qnh_set[ph]));
        write_reg(pta_pkg::CFG_OFFSET, 11'(off_set[ph] & 6'h3F));
        // ignored index must not disturb the registers
        write_reg(CFG_UNUSED, 11'($urandom));
      end
      send_idle = (ph / 2 == 0) ? 36 : (ph / 2 == 1) ? 77 : 0;
      recv_idle = (ph / 2 == 0) ? 77 : (ph / 2 == 1) ? 36 : 0;
      if (ph == 0) begin
        pressure_q = '{17'd0, 17'd1, 17'd1000, 17'd120000, 17'h1FFFF, 17'd101500,
                       17'd101300, 17'd65535, 17'd65536, 17'd50000, 17'd30000,
                       17'd200, 17'h0AAAA, 17'h15555, 17'd110000, 17'd1024};
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        r = $urandom_range(9);
        if (r < 7) pressure_q.push_back(pta_pkg::pressure_t'($urandom_range(120000, 1000)));
        else pressure_q.push_back(pta_pkg::pressure_t'($urandom));
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
